// File: hw/rtl/assert_macros.svh
// Assertion helpers for the percent codec RTL.
// Both macros take a label, a clock, an active-low reset and a property body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Plain concurrent check, disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/pctc_pkg.sv
`default_nettype none

package pctc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECODE_MODE    = 2'd0,
        CFG_KEEP_NEWLINES  = 2'd1,
        CFG_PLUS_FOR_SPACE = 2'd2
    } t_cfg_idx;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    // One queued job: either a single byte or a three-byte escape of data
    typedef struct packed {
        logic       triple;  // emit '%', high hex digit, low hex digit
        logic       bad;     // error word
        logic       eos;     // last word of the job closes the stream
        logic [7:0] data;
    } t_job;

endpackage

`default_nettype wire

// File: hw/rtl/pctc_front.sv
`default_nettype none

`include "assert_macros.svh"

module pctc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pctc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                           i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic [7:0]                     i_in_byte,
    input  wire logic                           i_end_of_stream,
    input  wire logic                           i_q_full,
    output logic                                o_in_stall,
    output logic                                o_push,
    output pctc_pkg::t_job                      o_job
);
    import pctc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HI   = 2'd1,
        PH_LO   = 2'd2
    } t_phase;

    logic       r_decode, r_keep_nl, r_plus;
    t_phase     r_phase, n_phase;
    logic [3:0] r_high, n_high;
    logic       r_aborted, n_aborted;

    logic       accept;
    logic       produce;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       plain;
    t_job       job;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept && produce;
    assign o_job      = job;

    // Hex digit value, either case
    always_comb begin
        is_hex  = 1'b1;
        hex_val = i_in_byte[3:0];
        if (i_in_byte inside {[8'h30:8'h39]}) begin
            hex_val = i_in_byte[3:0];
        end else if (i_in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            hex_val = i_in_byte[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    // Bytes that pass through unescaped when encoding
    always_comb begin
        plain = (i_in_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                                   CH_DASH, CH_DOT, CH_UNDER, CH_TILDE})
                || (r_keep_nl && i_in_byte == CH_NEWLINE);
    end

    // Classify the incoming byte and work out the next escape state
    always_comb begin
        n_phase   = r_phase;
        n_high    = r_high;
        n_aborted = r_aborted;
        produce   = 1'b0;
        job       = '{triple: 1'b0, bad: 1'b0, eos: i_end_of_stream, data: i_in_byte};
        if (!r_decode) begin
            produce = 1'b1;
            if (plain) begin
                job.data = i_in_byte;
            end else if (r_plus && i_in_byte == CH_SPACE) begin
                job.data = CH_PLUS;
            end else begin
                job.triple = 1'b1;
            end
        end else if (r_aborted) begin
            produce = 1'b0;
        end else if (r_phase == PH_IDLE) begin
            if (r_plus && i_in_byte == CH_PLUS) begin
                produce  = 1'b1;
                job.data = CH_SPACE;
            end else if (i_in_byte == CH_PERCENT) begin
                if (i_end_of_stream) begin
                    produce = 1'b1;
                    job     = '{triple: 1'b0, bad: 1'b1, eos: 1'b1, data: 8'h00};
                end else begin
                    n_phase = PH_HI;
                end
            end else begin
                produce = 1'b1;
            end
        end else if (!is_hex) begin
            // malformed escape: report once, drop the rest of the stream
            produce   = 1'b1;
            job       = '{triple: 1'b0, bad: 1'b1, eos: 1'b1, data: 8'h00};
            n_phase   = PH_IDLE;
            n_high    = 4'h0;
            n_aborted = 1'b1;
        end else if (r_phase == PH_HI) begin
            if (i_end_of_stream) begin
                produce = 1'b1;
                job     = '{triple: 1'b0, bad: 1'b1, eos: 1'b1, data: 8'h00};
            end else begin
                n_high  = hex_val;
                n_phase = PH_LO;
            end
        end else begin
            produce  = 1'b1;
            job.data = {r_high, hex_val};
            n_phase  = PH_IDLE;
            n_high   = 4'h0;
        end
        // a stream end always returns to a clean state
        if (i_end_of_stream) begin
            n_phase   = PH_IDLE;
            n_high    = 4'h0;
            n_aborted = 1'b0;
        end
    end

    // Config registers and escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode  <= 1'b0;
            r_keep_nl <= 1'b0;
            r_plus    <= 1'b0;
            r_phase   <= PH_IDLE;
            r_high    <= 4'h0;
            r_aborted <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DECODE_MODE:    r_decode  <= i_cfg_data;
                    CFG_KEEP_NEWLINES:  r_keep_nl <= i_cfg_data;
                    CFG_PLUS_FOR_SPACE: r_plus    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_high    <= n_high;
                r_aborted <= n_aborted;
            end
        end
    end

    `ASSERT_PROP(a_abort_idle, i_clk, i_rst_n, r_aborted |-> (r_phase == PH_IDLE))
    `ASSERT_PROP(a_bad_ends, i_clk, i_rst_n,
        (o_push && o_job.bad) |-> (o_job.eos && !o_job.triple && o_job.data == 8'h00))
    `ASSERT_PROP(a_eos_clears, i_clk, i_rst_n,
        (accept && i_end_of_stream) |=> (r_phase == PH_IDLE && r_high == 4'h0 && !r_aborted))

endmodule

`default_nettype wire

// File: hw/rtl/pctc_queue.sv
`default_nettype none

module pctc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pctc_pkg::t_job i_job,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output pctc_pkg::t_job     o_job
);
    import pctc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pctc_back.sv
`default_nettype none

`include "assert_macros.svh"

module pctc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  wire pctc_pkg::t_job i_q_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_run,
    output logic                o_bad_escape,
    output logic                o_stream_done
);
    import pctc_pkg::*;

    // Uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

    t_job       r_job;
    logic       r_valid;
    logic [1:0] r_beat;
    logic       last;
    logic       fire;

    assign last = !r_job.triple || (r_beat == 2'd2);
    assign fire = r_valid && !i_out_stall;
    assign o_pop = !i_q_empty && (!r_valid || (fire && last));

    // Output word from the held job and beat
    always_comb begin
        o_out_valid   = r_valid;
        o_last_of_run = last;
        o_bad_escape  = r_job.bad;
        o_stream_done = last && r_job.eos;
        o_out_byte    = r_job.data;
        if (r_job.triple) begin
            case (r_beat)
                2'd0:    o_out_byte = CH_PERCENT;
                2'd1:    o_out_byte = hex_char(r_job.data[7:4]);
                default: o_out_byte = hex_char(r_job.data[3:0]);
            endcase
        end
    end

    // Job holding register and beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_beat  <= 2'd0;
        end else if (fire) begin
            if (last) begin
                r_valid <= 1'b0;
                r_beat  <= 2'd0;
            end else begin
                r_beat <= r_beat + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    `ASSERT_PROP(a_bad_word, i_clk, i_rst_n,
        (o_out_valid && o_bad_escape) |-> (o_last_of_run && o_stream_done && o_out_byte == 8'h00))
    `ASSERT_PROP(a_escape_continues, i_clk, i_rst_n,
        (fire && !last) |=> (o_out_valid && r_job.triple))
    `ASSERT_NEVER(a_beat_range, i_clk, i_rst_n,
        (r_beat == 2'd3) || (r_beat != 2'd0 && !r_job.triple))

endmodule

`default_nettype wire

// File: hw/rtl/percent_encode_decode.sv
`default_nettype none

// Percent codec for a byte stream.
// Input channel: i_in_valid / o_in_stall carry one word (i_in_byte, i_end_of_stream).
// Output channel: o_out_valid / i_out_stall carry one word (o_out_byte,
// o_last_of_run, o_bad_escape, o_stream_done). A word moves at a clock edge with
// valid high and stall low.
// Config: i_cfg_we writes bit 0 of i_cfg_data into register i_cfg_idx
// (0 decode_mode, 1 keep_newlines, 2 plus_for_space); write only while idle.
// An input word that produces output is written into the job queue by the front,
// and the back then registers the job, whose held copy drives the first output word.
// Throughput: one output word per cycle while i_out_stall is low and jobs wait, set
// by the single output register; an escaped byte in encode mode gives 3 words, any
// other producing byte 1 word. Escape openers and dropped bytes write no job.
// The job queue of QUEUE_DEPTH entries lets input run ahead of a stalled receiver;
// o_in_stall rises only when that queue is full.
// Reset (synchronous, active low) clears config, escape state and the queue.

module percent_encode_decode #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pctc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                           i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_in_byte,
    input  wire logic                           i_end_of_stream,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [7:0]                          o_out_byte,
    output logic                                o_last_of_run,
    output logic                                o_bad_escape,
    output logic                                o_stream_done
);
    import pctc_pkg::*;

    logic q_full, q_empty, push, pop;
    t_job push_job, head_job;

    pctc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_q_full        (q_full),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_job           (push_job)
    );

    pctc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    pctc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_job       (head_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_bad_escape  (o_bad_escape),
        .o_stream_done (o_stream_done)
    );

endmodule

`default_nettype wire
